### src/fpd_pkg.sv
// Package for the framed packet deframer.
// Holds the framing constants and the result type shared by the receiver, top level and testbench.
package fpd_pkg;

   localparam logic [7:0] FRAME_MARK   = 8'hAA;
   localparam logic [7:0] ESC_DATA     = 8'hA5;
   localparam logic [7:0] ESC_MASK     = 8'h80;
   localparam int         BODY_LEN     = 10;
   localparam int         DATA_LEN     = 8;
   localparam int         COUNT_W      = $clog2(BODY_LEN + 1);

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [3:0]                   packet_id;
      logic [DATA_LEN-1:0][7:0]     payload;
   } rsp_type;

   typedef struct packed {
      logic    emit;
      rsp_type rsp;
   } rx_out_type;

endpackage

### src/fpd_if.sv
// Valid/ready channel interfaces for the deframer's byte input and packet output.
// Depends on nothing.
interface fpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface fpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] packet_id;
   logic [7:0] payload_0;
   logic [7:0] payload_1;
   logic [7:0] payload_2;
   logic [7:0] payload_3;
   logic [7:0] payload_4;
   logic [7:0] payload_5;
   logic [7:0] payload_6;
   logic [7:0] payload_7;

   modport source (output valid, output packet_id, output payload_0, output payload_1,
                   output payload_2, output payload_3, output payload_4, output payload_5,
                   output payload_6, output payload_7, input ready);
   modport sink (input valid, input packet_id, input payload_0, input payload_1,
                 input payload_2, input payload_3, input payload_4, input payload_5,
                 input payload_6, input payload_7, output ready);
endinterface

### src/fpd_rx.sv
// Frame receiver: phase tracking, body byte store and packet decode.
// Depends on fpd_pkg.
module fpd_rx (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  fpd_pkg::byte_type   rx_byte,
   output fpd_pkg::rx_out_type rx_out
);
   import fpd_pkg::*;

   localparam logic [1:0] PH_HEAD  = 2'd0;
   localparam logic [1:0] PH_BODY  = 2'd1;
   localparam logic [1:0] PH_TRAIL = 2'd2;

   logic [1:0]         phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   byte_type           store_ff [BODY_LEN];
   logic               mark;
   logic               store_we;
   logic               pid_ok;
   byte_type           pid;
   byte_type           mask;

   assign mark = (rx_byte == FRAME_MARK);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      store_we = 1'b0;
      if (step) begin
         unique case (phase_ff)
            PH_BODY: begin
               if (mark) begin
                  if (count_ff != '0) begin
                     phase_in = PH_HEAD;
                     count_in = '0;
                  end
               end else if (count_ff < COUNT_W'(BODY_LEN)) begin
                  store_we = 1'b1;
                  count_in = count_ff + COUNT_W'(1);
                  if (count_in == COUNT_W'(BODY_LEN)) begin
                     phase_in = PH_TRAIL;
                  end
               end
            end
            PH_TRAIL: begin
               phase_in = PH_HEAD;
               if (!mark) begin
                  count_in = '0;
               end
            end
            default: begin
               if (mark) begin
                  phase_in = PH_BODY;
                  count_in = '0;
               end else begin
                  phase_in = PH_HEAD;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BODY_LEN; i++) begin
         if (store_we && count_ff == COUNT_W'(i)) begin
            store_ff[i] <= rx_byte;
         end
      end
   end

   // The mask byte 0x80 with data byte 7 equal to 0xA5 stands for a mask of 0xAA.
   always_comb begin
      pid    = store_ff[0];
      pid_ok = (pid[7:4] == ~pid[3:0]);
      mask   = store_ff[BODY_LEN-1];
      if (store_ff[DATA_LEN] == ESC_DATA && mask == ESC_MASK) begin
         mask = FRAME_MARK;
      end
      rx_out.emit          = step && (phase_ff == PH_TRAIL) && mark && pid_ok;
      rx_out.rsp.packet_id = pid[7:4];
      for (int i = 0; i < DATA_LEN; i++) begin
         rx_out.rsp.payload[i] = mask[i] ? FRAME_MARK : store_ff[i+1];
      end
   end

endmodule

### src/framed_packet_deframer.sv
// Top level of the framed packet deframer: input register, frame receiver and
// a two-entry result queue. Depends on fpd_pkg, fpd_if and fpd_rx.
//
//   Channel   Direction  Payload                               Transfer
//   req_ch    in         rx_byte[7:0]                          valid && ready
//   rsp_ch    out        packet_id[3:0], payload_0..7[7:0]     valid && ready
//
// One byte per cycle is taken unless input stalls; a result is registered behind the input register.
// The rate is set by the single decode pass between the input register and the
// result queue, which holds up to two results.
// Synchronous reset returns the receiver to waiting for a header and empties the queue.
// Input stalls only when the queue is full and a byte waits in the input register.
module framed_packet_deframer (
   input logic         clock,
   input logic         reset,
   fpd_req_if.sink     req_ch,
   fpd_rsp_if.source   rsp_ch
);
   import fpd_pkg::*;

   logic       in_valid_ff;
   byte_type   in_byte_ff;
   logic       advance;
   rx_out_type rx_out;
   rsp_type    head_ff;
   rsp_type    skid_ff;
   logic       head_valid_ff;
   logic       skid_valid_ff;
   logic       pop;

   assign advance      = in_valid_ff && !skid_valid_ff;
   assign req_ch.ready = !in_valid_ff || advance;
   assign pop          = head_valid_ff && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   fpd_rx u_rx (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .rx_out  (rx_out)
   );

   // A push lands only while the skid entry is empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!head_valid_ff || pop) begin
            head_valid_ff <= skid_valid_ff || rx_out.emit;
            skid_valid_ff <= 1'b0;
         end else if (rx_out.emit) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!head_valid_ff || pop) begin
         head_ff <= skid_valid_ff ? skid_ff : rx_out.rsp;
      end
      if (rx_out.emit && !skid_valid_ff) begin
         skid_ff <= rx_out.rsp;
      end
   end

   assign rsp_ch.valid     = head_valid_ff;
   assign rsp_ch.packet_id = head_ff.packet_id;
   assign rsp_ch.payload_0 = head_ff.payload[0];
   assign rsp_ch.payload_1 = head_ff.payload[1];
   assign rsp_ch.payload_2 = head_ff.payload[2];
   assign rsp_ch.payload_3 = head_ff.payload[3];
   assign rsp_ch.payload_4 = head_ff.payload[4];
   assign rsp_ch.payload_5 = head_ff.payload[5];
   assign rsp_ch.payload_6 = head_ff.payload[6];
   assign rsp_ch.payload_7 = head_ff.payload[7];

endmodule

### src/fpd_checker.sv
// Port-level checks for the framed packet deframer, attached by a bind statement.
// Depends on framed_packet_deframer and fpd_if.
module fpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_packet_id,
   input logic [7:0] rsp_payload_0
);

   a_reset_empty : assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("Result valid right after reset.");

   a_stall_needs_result : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("Input stalled with no result waiting.");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
      else $error("Input stall began without a stalled result transfer.");

   a_result_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packet_id)
                                  && $stable(rsp_payload_0))
      else $error("Stalled result changed.");

endmodule

bind framed_packet_deframer fpd_checker u_fpd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_packet_id (rsp_ch.packet_id),
   .rsp_payload_0 (rsp_ch.payload_0)
);

### sim/fpd_frame_check.sv
`timescale 1ns / 1ps
// Checker for the framed packet deframer: tracks the frame receiver from the accepted
// bytes, predicts each packet and compares it with what the output channel delivers.
// Depends on fpd_pkg and the channel interfaces of fpd_if.
module fpd_frame_check (
   input  logic clock,
   input  logic reset,
   fpd_req_if   req_ch,
   fpd_rsp_if   rsp_ch,
   output int   fail_count,
   output int   pending,
   output int   predicted,
   output int   checked
);
   import fpd_pkg::*;

   typedef enum logic [1:0] {
      HUNT       = 2'd0,
      IN_BODY    = 2'd1,
      AT_TRAILER = 2'd2
   } rx_phase_type;

   rx_phase_type rx_phase;
   logic [3:0]   body_count;
   byte_type     body_store [BODY_LEN];
   rsp_type      packets_due [$];
   int           fails = 0;
   int           n_pred = 0;
   int           n_checked = 0;

   task automatic report(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      fails++;
   endtask

   task automatic clear_body();
      body_count = '0;
      foreach (body_store[i]) body_store[i] = '0;
   endtask

   task automatic deframe_byte(input byte_type b);
      byte_type pid;
      byte_type mask;
      rsp_type  pkt;
      case (rx_phase)
         IN_BODY: begin
            if (b == FRAME_MARK) begin
               if (body_count != 0) begin
                  rx_phase = HUNT;
                  clear_body();
               end
            end else if (body_count < BODY_LEN) begin
               body_store[body_count] = b;
               body_count++;
               if (body_count == BODY_LEN) rx_phase = AT_TRAILER;
            end
         end
         AT_TRAILER: begin
            rx_phase = HUNT;
            if (b != FRAME_MARK) begin
               clear_body();
            end else begin
               pid = body_store[0];
               mask = body_store[BODY_LEN-1];
               if (pid[7:4] == ~pid[3:0]) begin
                  // The escaped mask stands for the one value that cannot travel in the body.
                  if (body_store[DATA_LEN] == ESC_DATA && mask == ESC_MASK) mask = FRAME_MARK;
                  pkt.packet_id = pid[7:4];
                  for (int i = 0; i < DATA_LEN; i++) begin
                     pkt.payload[i] = mask[i] ? FRAME_MARK : body_store[i+1];
                  end
                  packets_due.push_back(pkt);
                  n_pred++;
               end
            end
         end
         default: begin
            if (b == FRAME_MARK) begin
               rx_phase = IN_BODY;
               clear_body();
            end else begin
               rx_phase = HUNT;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : monitor
      rsp_type  want;
      byte_type got_pl [DATA_LEN];
      if (reset) begin
         rx_phase = HUNT;
         clear_body();
         packets_due.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) deframe_byte(req_ch.rx_byte);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_pl = '{rsp_ch.payload_0, rsp_ch.payload_1, rsp_ch.payload_2, rsp_ch.payload_3,
                       rsp_ch.payload_4, rsp_ch.payload_5, rsp_ch.payload_6, rsp_ch.payload_7};
            if (packets_due.size() == 0) begin
               report($sformatf("packet with id %0h arrived with no packet due",
                                rsp_ch.packet_id));
            end else begin
               want = packets_due.pop_front();
               n_checked++;
               if (rsp_ch.packet_id !== want.packet_id) begin
                  report($sformatf("packet_id got %0h expected %0h",
                                   rsp_ch.packet_id, want.packet_id));
               end
               for (int i = 0; i < DATA_LEN; i++) begin
                  if (got_pl[i] !== want.payload[i]) begin
                     report($sformatf("payload_%0d got %02h expected %02h",
                                      i, got_pl[i], want.payload[i]));
                  end
               end
            end
         end
      end
      fail_count <= fails;
      pending    <= packets_due.size();
      predicted  <= n_pred;
      checked    <= n_checked;
   end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, byte stimulus, output stalls and verdict.
// Depends on fpd_pkg, fpd_if, framed_packet_deframer and fpd_frame_check.
module tb_top;
   import fpd_pkg::*;

   localparam int ITEM_TARGET   = 550;
   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 10;

   logic clock;
   logic reset;
   bit   hold_toggle = 1'b0;
   bit   no_gaps = 1'b0;
   int   burst_left = 0;
   int   items_sent = 0;
   int   n_good = 0;
   int   n_bad_pid = 0;
   int   n_bad_trailer = 0;
   int   n_abort = 0;
   int   n_escape = 0;
   int   fail_count;
   int   pending;
   int   predicted;
   int   checked;

   fpd_req_if req_ch ();
   fpd_rsp_if rsp_ch ();

   framed_packet_deframer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   fpd_frame_check frame_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending),
      .predicted  (predicted),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic byte_type rand_body();
      byte_type b;
      do b = byte_type'($urandom_range(0, 255)); while (b == FRAME_MARK);
      return b;
   endfunction

   task automatic send_byte(input byte_type b, input bit counted);
      int gap;
      if (burst_left == 0) begin
         gap = no_gaps ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (counted) items_sent++;
   endtask

   task automatic send_frame(input byte_type pid, input byte_type data [DATA_LEN],
                             input byte_type mask, input byte_type trailer,
                             input int extra_headers);
      repeat (1 + extra_headers) send_byte(FRAME_MARK, 1'b1);
      send_byte(pid, 1'b1);
      foreach (data[i]) send_byte(data[i], 1'b1);
      send_byte(mask, 1'b1);
      send_byte(trailer, 1'b1);
   endtask

   task automatic send_good_frame();
      byte_type   data [DATA_LEN];
      byte_type   mask;
      logic [3:0] hi;
      hi = 4'($urandom_range(0, 15));
      foreach (data[i]) data[i] = rand_body();
      case ($urandom_range(0, 5))
         0: begin
            data[DATA_LEN-1] = ESC_DATA;
            mask = ESC_MASK;
            n_escape++;
         end
         1: begin
            data[DATA_LEN-1] = ESC_DATA;
            mask = rand_body();
         end
         2: mask = ESC_MASK;
         3: mask = 8'hFF;
         default: mask = rand_body();
      endcase
      send_frame({hi, ~hi}, data, mask, FRAME_MARK, ($urandom_range(0, 3) == 0) ? 1 : 0);
      n_good++;
   endtask

   // The output side keeps a stall pattern of its own and honors one long hold-off request.
   initial begin : receiver
      bit last_toggle;
      int mode;
      int span;
      int tick;
      last_toggle = 1'b0;
      mode = 0;
      span = 0;
      tick = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_toggle != last_toggle) begin
            last_toggle = hold_toggle;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 2);
               span = $urandom_range(20, 80);
            end
            span--;
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ch.ready <= ((tick % 6) >= 2);
            endcase
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle = 0;
         else idle++;
      end
      $display("Watchdog: no transfer for %0d cycles.", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      byte_type   frame_data [DATA_LEN];
      byte_type   pid;
      logic [3:0] hi;
      int         kind;
      int         seg_end;
      bit         held;
      held = 1'b0;
      seg_end = 100;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      frame_data = '{8'h00, 8'hFF, 8'h55, 8'h01, 8'h80, 8'h7F, 8'hFE, ESC_DATA};
      send_frame(8'h0F, frame_data, 8'h00, FRAME_MARK, 1);
      n_good++;
      send_byte(FRAME_MARK, 1'b1);
      send_byte(8'h01, 1'b1);
      send_byte(FRAME_MARK, 1'b1);
      n_abort++;
      frame_data = '{8'h5A, 8'hFF, 8'h00, 8'h33, 8'hCC, 8'h0F, 8'hF0, ESC_DATA};
      send_frame(8'hF0, frame_data, ESC_MASK, FRAME_MARK, 0);
      n_good++;
      n_escape++;

      while (items_sent < ITEM_TARGET) begin
         if (!held && items_sent >= 200) begin
            held = 1'b1;
            no_gaps = 1'b1;
            hold_toggle <= ~hold_toggle;
            repeat (6) send_good_frame();
         end
         if (items_sent >= seg_end) begin
            no_gaps = ($urandom_range(0, 2) == 0);
            seg_end = items_sent + 100;
         end
         kind = $urandom_range(0, 99);
         if (kind < 62) begin
            send_good_frame();
         end else if (kind < 72) begin
            do pid = rand_body(); while (pid[7:4] == ~pid[3:0]);
            foreach (frame_data[i]) frame_data[i] = rand_body();
            send_frame(pid, frame_data, rand_body(), FRAME_MARK, 0);
            n_bad_pid++;
         end else if (kind < 80) begin
            hi = 4'($urandom_range(0, 15));
            foreach (frame_data[i]) frame_data[i] = rand_body();
            send_frame({hi, ~hi}, frame_data, rand_body(), rand_body(), 0);
            n_bad_trailer++;
         end else if (kind < 90) begin
            send_byte(FRAME_MARK, 1'b1);
            repeat ($urandom_range(1, BODY_LEN - 1)) send_byte(rand_body(), 1'b1);
            send_byte(FRAME_MARK, 1'b1);
            n_abort++;
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(rand_body(), 1'b0);
         end
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d frame bytes: %0d good frames (%0d with escaped mask), %0d bad PID,",
               items_sent, n_good, n_escape, n_bad_pid);
      $display("%0d bad trailers, %0d aborted bodies; %0d of %0d packets checked.",
               n_bad_trailer, n_abort, checked, predicted);
      $display("The output side held off once for %0d cycles.", HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
